// File: sv/tap_pkg.sv
`default_nettype none
package tap_pkg;
    localparam int CordicIterations = 16;
    localparam int AngleTableLen    = 24;
    localparam int CordicW          = 38;
    localparam int AngleW           = 27;

    localparam logic [AngleW-1:0] Deg180Q16  = 27'sd11796480;
    localparam logic [15:0]       InvGainQ16 = 16'd39796;

    typedef enum logic [2:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_I   = 3'd1,
        REG_GAIN_D   = 3'd2,
        REG_GOAL_X   = 3'd3,
        REG_GOAL_Y   = 3'd4,
        REG_FW_BASE  = 3'd5,
        REG_FW_SCALE = 3'd6,
        REG_FW_LOW   = 3'd7
    } t_reg_index;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_ITER, ST_BEAR, ST_DIST, ST_ERR,
        ST_MUL_P, ST_MUL_D, ST_MUL_I, ST_SCALE, ST_FLY, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic iter;
        logic bear;
        logic span;
        logic err;
        logic mul_p;
        logic mul_d;
        logic mul_i;
        logic scale;
        logic fly;
    } t_cmd;

    typedef struct packed {
        logic iter_last;
    } t_status;

    function automatic logic [AngleW-1:0] atan_q16(input logic [4:0] i);
        logic [AngleW-1:0] v;
        case (i)
            5'd0:  v = 27'd2949120;
            5'd1:  v = 27'd1740967;
            5'd2:  v = 27'd919879;
            5'd3:  v = 27'd466945;
            5'd4:  v = 27'd234379;
            5'd5:  v = 27'd117304;
            5'd6:  v = 27'd58666;
            5'd7:  v = 27'd29335;
            5'd8:  v = 27'd14668;
            5'd9:  v = 27'd7334;
            5'd10: v = 27'd3667;
            5'd11: v = 27'd1833;
            5'd12: v = 27'd917;
            5'd13: v = 27'd458;
            5'd14: v = 27'd229;
            5'd15: v = 27'd115;
            5'd16: v = 27'd57;
            5'd17: v = 27'd29;
            5'd18: v = 27'd14;
            5'd19: v = 27'd7;
            5'd20: v = 27'd4;
            5'd21: v = 27'd2;
            5'd22: v = 27'd1;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// File: sv/tap_in_if.sv
`default_nettype none
interface tap_in_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] robot_x;
    logic signed [14:0] robot_y;
    logic        [14:0] turret_heading;
    logic               button_fast;
    logic               button_slow;
    logic               button_stop;
    modport source (output valid, robot_x, robot_y, turret_heading,
                    button_fast, button_slow, button_stop, input ready);
    modport sink   (input valid, robot_x, robot_y, turret_heading,
                    button_fast, button_slow, button_stop, output ready);
endinterface
`default_nettype wire

// File: sv/tap_out_if.sv
`default_nettype none
interface tap_out_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] turret_velocity;
    logic        [9:0] flywheel_velocity;
    logic              flywheel_update;
    modport source (output valid, turret_velocity, flywheel_velocity, flywheel_update,
                    input ready);
    modport sink   (input valid, turret_velocity, flywheel_velocity, flywheel_update,
                    output ready);
endinterface
`default_nettype wire

// File: sv/tap_ctrl.sv
`default_nettype none
module tap_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire tap_pkg::t_status i_status,
    output tap_pkg::t_cmd        o_cmd
);
    tap_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tap_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tap_pkg::ST_IDLE:  if (i_in_valid) n_state = tap_pkg::ST_PREP;
            tap_pkg::ST_PREP:  n_state = tap_pkg::ST_ITER;
            tap_pkg::ST_ITER:  if (i_status.iter_last) n_state = tap_pkg::ST_BEAR;
            tap_pkg::ST_BEAR:  n_state = tap_pkg::ST_DIST;
            tap_pkg::ST_DIST:  n_state = tap_pkg::ST_ERR;
            tap_pkg::ST_ERR:   n_state = tap_pkg::ST_MUL_P;
            tap_pkg::ST_MUL_P: n_state = tap_pkg::ST_MUL_D;
            tap_pkg::ST_MUL_D: n_state = tap_pkg::ST_MUL_I;
            tap_pkg::ST_MUL_I: n_state = tap_pkg::ST_SCALE;
            tap_pkg::ST_SCALE: n_state = tap_pkg::ST_FLY;
            tap_pkg::ST_FLY:   n_state = tap_pkg::ST_OUT;
            tap_pkg::ST_OUT:   if (i_out_ready) n_state = tap_pkg::ST_IDLE;
            default:           n_state = tap_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            tap_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            tap_pkg::ST_PREP:  o_cmd.prep  = 1'b1;
            tap_pkg::ST_ITER:  o_cmd.iter  = 1'b1;
            tap_pkg::ST_BEAR:  o_cmd.bear  = 1'b1;
            tap_pkg::ST_DIST:  o_cmd.span  = 1'b1;
            tap_pkg::ST_ERR:   o_cmd.err   = 1'b1;
            tap_pkg::ST_MUL_P: o_cmd.mul_p = 1'b1;
            tap_pkg::ST_MUL_D: o_cmd.mul_d = 1'b1;
            tap_pkg::ST_MUL_I: o_cmd.mul_i = 1'b1;
            tap_pkg::ST_SCALE: o_cmd.scale = 1'b1;
            tap_pkg::ST_FLY:   o_cmd.fly   = 1'b1;
            tap_pkg::ST_OUT:   o_out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// File: sv/tap_datapath.sv
`default_nettype none
module tap_datapath #(
    parameter int CORDIC_ITERATIONS = tap_pkg::CordicIterations
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tap_pkg::t_cmd      i_cmd,
    output tap_pkg::t_status        o_status,
    input  wire logic signed [14:0] i_robot_x,
    input  wire logic signed [14:0] i_robot_y,
    input  wire logic        [14:0] i_heading,
    input  wire logic               i_fast,
    input  wire logic               i_slow,
    input  wire logic               i_stop,
    input  wire logic        [11:0] i_gain_p,
    input  wire logic        [11:0] i_gain_i,
    input  wire logic        [11:0] i_gain_d,
    input  wire logic signed [14:0] i_goal_x,
    input  wire logic signed [14:0] i_goal_y,
    input  wire logic        [9:0]  i_fw_base,
    input  wire logic        [7:0]  i_fw_scale,
    input  wire logic        [9:0]  i_fw_low,
    output logic signed [8:0]       o_turret_velocity,
    output logic        [9:0]       o_flywheel_velocity,
    output logic                    o_flywheel_update
);
    localparam int CW = tap_pkg::CordicW;
    localparam int AW = tap_pkg::AngleW;
    localparam int NIter = (CORDIC_ITERATIONS > tap_pkg::AngleTableLen) ?
                           tap_pkg::AngleTableLen : CORDIC_ITERATIONS;
    localparam logic [4:0] LastIter = 5'(NIter - 1);

    logic signed [15:0] r_dx, r_dy;
    logic        [14:0] r_heading;
    logic               r_fast, r_slow, r_stop;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [AW-1:0] r_z;
    logic        [4:0]  r_i;
    logic               r_zero;
    logic signed [17:0] r_bearing;
    logic        [16:0] r_dist;
    logic signed [15:0] r_err, r_prev;
    logic signed [16:0] r_deriv;
    logic signed [23:0] r_integ;
    logic signed [38:0] r_sum;
    logic signed [8:0]  r_vel;
    logic        [9:0]  r_fw;
    logic               r_upd;

    logic signed [CW-1:0] xs, ys;
    logic                 ypos;
    logic signed [AW-1:0] atan_v;
    logic signed [AW:0]   z_r;
    logic signed [CW+16:0] dist_prod;
    logic signed [18:0]  err_raw;
    logic signed [18:0]  err_w;
    logic signed [24:0]  integ_sum;
    logic signed [23:0]  integ_sat;
    logic signed [16:0]  deriv_w;
    logic signed [38:0]  mul_res;
    logic signed [39:0]  sum_r;
    logic signed [25:0]  sum_sh;
    logic        [25:0]  fw_prod;
    logic        [16:0]  fw_add;
    logic        [17:0]  fw_tot;

    assign o_status.iter_last = (r_i == LastIter);

    always_comb begin
        xs     = r_x >>> r_i;
        ys     = r_y >>> r_i;
        ypos   = (r_y > 0);
        atan_v = tap_pkg::atan_q16(r_i);
        z_r    = {r_z[AW-1], r_z} + (AW+1)'(512);
        dist_prod = $signed({{17{r_x[CW-1]}}, r_x}) * $signed({39'd0, tap_pkg::InvGainQ16});
        err_raw = {r_bearing[17], r_bearing} - $signed({4'd0, r_heading});
        if (err_raw < -19'sd11520)      err_w = err_raw + 19'sd23040;
        else if (err_raw > 19'sd11520)  err_w = err_raw - 19'sd23040;
        else                            err_w = err_raw;
        deriv_w  = {r_err[15], r_err} - {r_prev[15], r_prev};
        integ_sum = {r_integ[23], r_integ} + 25'(r_err);
        if (integ_sum > 25'sd8388607)       integ_sat = 24'sh7FFFFF;
        else if (integ_sum < -25'sd8388608) integ_sat = 24'sh800000;
        else                                integ_sat = integ_sum[23:0];
        if (r_err < 0 || r_err > 16'sd1280) integ_sat = '0;
        mul_res = '0;
        if (i_cmd.mul_p) mul_res = 39'(r_err * $signed({1'b0, i_gain_p}));
        if (i_cmd.mul_d) mul_res = 39'(r_deriv * $signed({1'b0, i_gain_d}));
        if (i_cmd.mul_i) mul_res = 39'(r_integ * $signed({1'b0, i_gain_i}));
        sum_r  = {r_sum[38], r_sum} + 40'sd8192;
        sum_sh = sum_r[39:14];
        fw_prod = r_dist * i_fw_scale;
        fw_add  = 17'((fw_prod + 26'd512) >> 10);
        fw_tot  = {8'd0, i_fw_base} + {1'b0, fw_add};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_integ <= '0;
        end else begin
            if (i_cmd.err) r_prev <= r_err;
            if (i_cmd.mul_p) r_integ <= integ_sat;
        end
        if (i_cmd.load) begin
            r_dx      <= {i_goal_x[14], i_goal_x} - {i_robot_x[14], i_robot_x};
            r_dy      <= {i_goal_y[14], i_goal_y} - {i_robot_y[14], i_robot_y};
            r_heading <= i_heading;
            r_fast    <= i_fast;
            r_slow    <= i_slow;
            r_stop    <= i_stop;
        end
        if (i_cmd.prep) begin
            r_i    <= '0;
            r_zero <= (r_dx == 0) && (r_dy == 0);
            if (r_dy < 0) begin
                r_x <= -(CW'(r_dy) <<< 14);
                r_y <= -(CW'(r_dx) <<< 14);
                r_z <= (r_dx >= 0) ? tap_pkg::Deg180Q16 : -tap_pkg::Deg180Q16;
            end else begin
                r_x <= CW'(r_dy) <<< 14;
                r_y <= CW'(r_dx) <<< 14;
                r_z <= '0;
            end
        end
        if (i_cmd.iter) begin
            r_i <= r_i + 5'd1;
            if (ypos) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_v;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_v;
            end
        end
        if (i_cmd.bear) begin
            r_bearing <= r_zero ? '0 : 18'(z_r >>> 10);
            r_x       <= (r_x < 0) ? '0 : r_x;
        end
        if (i_cmd.span) begin
            r_dist <= r_zero ? '0 : 17'((dist_prod + (55'sd1 <<< 29)) >>> 30);
            r_err  <= 16'(err_w);
        end
        if (i_cmd.err) r_deriv <= deriv_w;
        if (i_cmd.mul_p) r_sum <= mul_res;
        if (i_cmd.mul_d || i_cmd.mul_i) r_sum <= r_sum + mul_res;
        if (i_cmd.scale) begin
            if (sum_sh > 26'sd200)       r_vel <= 9'sd200;
            else if (sum_sh < -26'sd200) r_vel <= -9'sd200;
            else                         r_vel <= sum_sh[8:0];
        end
        if (i_cmd.fly) begin
            if (r_fast) begin
                r_fw  <= (fw_tot > 18'd600) ? 10'd600 : fw_tot[9:0];
                r_upd <= 1'b1;
            end else if (r_slow) begin
                r_fw  <= (i_fw_low > 10'd600) ? 10'd600 : i_fw_low;
                r_upd <= 1'b1;
            end else begin
                r_fw  <= '0;
                r_upd <= r_stop;
            end
        end
    end

    assign o_turret_velocity   = r_vel;
    assign o_flywheel_velocity = r_fw;
    assign o_flywheel_update   = r_upd;
endmodule
`default_nettype wire

// File: sv/turret_aim_pid_top.sv
`default_nettype none
// Channel    | Dir | Payload
// in_req     | in  | robot_x, robot_y, turret_heading, button_fast/slow/stop
// out_req    | out | turret_velocity, flywheel_velocity, flywheel_update
// cfg write  | in  | i_cfg_we, i_cfg_index, i_cfg_data (no read-back)
// The result is valid after the request steps through the prep, iterative CORDIC,
// bearing, range, error, PID multiply, scale and flywheel states, in that order.
// One request in flight at a time; a new request is taken only after the sink
// has accepted the previous result.
// Reset is synchronous, active low; it restores the register defaults and
// clears the error history and the integral.
// A stalled result holds in its register until the sink takes it.
module turret_aim_pid_top #(
    parameter int CORDIC_ITERATIONS = tap_pkg::CordicIterations
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tap_in_if.sink           in_req,
    tap_out_if.source        out_req,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [14:0] i_cfg_data
);
    logic        [11:0] r_gain_p, r_gain_i, r_gain_d;
    logic signed [14:0] r_goal_x, r_goal_y;
    logic        [9:0]  r_fw_base, r_fw_low;
    logic        [7:0]  r_fw_scale;
    tap_pkg::t_cmd      cmd;
    tap_pkg::t_status   status;

    // Hold the configuration registers; write one per enabled cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p   <= 12'd640;
            r_gain_i   <= 12'd0;
            r_gain_d   <= 12'd205;
            r_goal_x   <= 15'sd3072;
            r_goal_y   <= 15'sd3072;
            r_fw_base  <= 10'd380;
            r_fw_scale <= 8'd32;
            r_fw_low   <= 10'd300;
        end else if (i_cfg_we) begin
            case (tap_pkg::t_reg_index'(i_cfg_index))
                tap_pkg::REG_GAIN_P:   r_gain_p   <= i_cfg_data[11:0];
                tap_pkg::REG_GAIN_I:   r_gain_i   <= i_cfg_data[11:0];
                tap_pkg::REG_GAIN_D:   r_gain_d   <= i_cfg_data[11:0];
                tap_pkg::REG_GOAL_X:   r_goal_x   <= i_cfg_data;
                tap_pkg::REG_GOAL_Y:   r_goal_y   <= i_cfg_data;
                tap_pkg::REG_FW_BASE:  r_fw_base  <= i_cfg_data[9:0];
                tap_pkg::REG_FW_SCALE: r_fw_scale <= i_cfg_data[7:0];
                tap_pkg::REG_FW_LOW:   r_fw_low   <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Sequence the request through the shared datapath.
    tap_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_req.valid),
        .o_in_ready  (in_req.ready),
        .o_out_valid (out_req.valid),
        .i_out_ready (out_req.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Geometry, PID and flywheel selection.
    tap_datapath #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_robot_x           (in_req.robot_x),
        .i_robot_y           (in_req.robot_y),
        .i_heading           (in_req.turret_heading),
        .i_fast              (in_req.button_fast),
        .i_slow              (in_req.button_slow),
        .i_stop              (in_req.button_stop),
        .i_gain_p            (r_gain_p),
        .i_gain_i            (r_gain_i),
        .i_gain_d            (r_gain_d),
        .i_goal_x            (r_goal_x),
        .i_goal_y            (r_goal_y),
        .i_fw_base           (r_fw_base),
        .i_fw_scale          (r_fw_scale),
        .i_fw_low            (r_fw_low),
        .o_turret_velocity   (out_req.turret_velocity),
        .o_flywheel_velocity (out_req.flywheel_velocity),
        .o_flywheel_update   (out_req.flywheel_update)
    );
endmodule
`default_nettype wire

// File: tb/tb_aim_if.sv
`default_nettype none
// Testbench-side copies are not needed; the RTL interfaces are used directly.
// This file holds the helper package for the bench.
package tb_aim_pkg;
    typedef struct {
        logic signed [8:0] turret_velocity;
        logic        [9:0] flywheel_velocity;
        logic              flywheel_update;
    } t_aim_result;
endpackage
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tap_pkg::*;
    import tb_aim_pkg::*;

    localparam int CycleLimit = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [14:0] i_cfg_data;

    tap_in_if  in_req();
    tap_out_if out_req();

    turret_aim_pid_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_req(in_req), .out_req(out_req),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the register file and of the controller history
    logic [11:0]        kp, ki, kd;
    logic signed [14:0] aim_x, aim_y;
    logic [9:0]         fw_base, fw_low;
    logic [7:0]         fw_scale;
    longint             last_err, err_sum;

    t_aim_result expected_cmds[$];
    int  mismatches;
    int  cycles;
    bit  stress_sink;   // when set, the sink stalls more often

    localparam longint AtanQ16[24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Count cycles and give up on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Floor division by a power of two
    function automatic longint floor_shift(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Bearing and range to the goal by CORDIC vectoring
    task automatic aim_geometry(input longint dx, input longint dy,
                                output longint bearing, output longint span);
        longint x, y, z, xs, ys;
        x = dy * 16384;
        y = dx * 16384;
        z = 0;
        if (dx == 0 && dy == 0) begin
            bearing = 0;
            span = 0;
        end else begin
            if (x < 0) begin
                z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < CordicIterations; i++) begin
                xs = floor_shift(x, i);
                ys = floor_shift(y, i);
                if (y > 0) begin
                    x = x + ys; y = y - xs; z = z + AtanQ16[i];
                end else begin
                    x = x - ys; y = y + xs; z = z - AtanQ16[i];
                end
            end
            bearing = floor_shift(z + 512, 10);
            if (x < 0) x = 0;
            span = floor_shift(x * 39796 + (64'sd1 << 29), 30);
        end
    endtask

    // Work out the command for one tick and advance the shadow history
    task automatic predict_command(input logic signed [14:0] rx, input logic signed [14:0] ry,
                                   input logic [14:0] hdg, input logic bf, input logic bs,
                                   input logic bt);
        longint bearing, span, err, deriv, integ, sum, vel, fw;
        t_aim_result r;
        aim_geometry(longint'(aim_x) - longint'(rx), longint'(aim_y) - longint'(ry),
                     bearing, span);
        err = bearing - longint'(hdg);
        if (err < -11520) err += 23040;
        else if (err > 11520) err -= 23040;
        err = clip(err, -32768, 32767);
        deriv = err - last_err;
        last_err = err;
        integ = clip(err_sum + err, -8388608, 8388607);
        if (err < 0 || err > 1280) integ = 0;
        err_sum = integ;
        sum = err * kp + deriv * kd + integ * ki;
        vel = clip(floor_shift(sum + 8192, 14), -200, 200);
        fw = 0;
        r.flywheel_update = 1'b1;
        if (bf) fw = clip(longint'(fw_base) + floor_shift(span * fw_scale + 512, 10), 0, 600);
        else if (bs) fw = clip(longint'(fw_low), 0, 600);
        else if (!bt) r.flywheel_update = 1'b0;
        r.turret_velocity = vel[8:0];
        r.flywheel_velocity = fw[9:0];
        expected_cmds.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("mismatch %s: got %0d want %0d", what, got, want);
    endtask

    // Check every accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_aim_result w;
        if (i_rst_n && out_req.valid && out_req.ready) begin
            if (expected_cmds.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                w = expected_cmds.pop_front();
                if (out_req.turret_velocity !== w.turret_velocity)
                    report_mismatch("turret_velocity", out_req.turret_velocity,
                                    w.turret_velocity);
                if (out_req.flywheel_velocity !== w.flywheel_velocity)
                    report_mismatch("flywheel_velocity", out_req.flywheel_velocity,
                                    w.flywheel_velocity);
                if (out_req.flywheel_update !== w.flywheel_update)
                    report_mismatch("flywheel_update", out_req.flywheel_update,
                                    w.flywheel_update);
            end
        end
    end

    // Random back-pressure on the result side: mostly short stalls, a few long
    initial begin
        int n;
        out_req.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            n = $urandom_range(0, 99);
            if (n < (stress_sink ? 40 : 10)) begin
                out_req.ready <= 1'b0;
                repeat ($urandom_range(1, (n < 3) ? 60 : 4)) @(posedge i_clk);
            end
            out_req.ready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 50) return 0;
        if (n < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // Offer one request, hold it until accepted, drop valid and predict its result
    task automatic send_request(input logic signed [14:0] rx, input logic signed [14:0] ry,
                                input logic [14:0] hdg, input logic bf, input logic bs,
                                input logic bt);
        in_req.valid          <= 1'b1;
        in_req.robot_x        <= rx;
        in_req.robot_y        <= ry;
        in_req.turret_heading <= hdg;
        in_req.button_fast    <= bf;
        in_req.button_slow    <= bs;
        in_req.button_stop    <= bt;
        do @(posedge i_clk); while (!in_req.ready);
        in_req.valid <= 1'b0;
        predict_command(rx, ry, hdg, bf, bs, bt);
        repeat (1 + pick_gap()) @(posedge i_clk);
    endtask

    task automatic send_random_request();
        logic [2:0] b;
        b = 3'($urandom);
        send_request(15'($urandom), 15'($urandom),
                     ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 23039)),
                     b[0], b[1], b[2]);
    endtask

    // Wait until every result has drained, then a margin for the pipeline
    task automatic drain_results();
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (CordicIterations + 20) @(posedge i_clk);
    endtask

    // Write one register while the block is idle, and mirror it
    task automatic write_register(input t_reg_index idx, input logic [14:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_GAIN_P:   kp = value[11:0];
            REG_GAIN_I:   ki = value[11:0];
            REG_GAIN_D:   kd = value[11:0];
            REG_GOAL_X:   aim_x = value;
            REG_GOAL_Y:   aim_y = value;
            REG_FW_BASE:  fw_base = value[9:0];
            REG_FW_SCALE: fw_scale = value[7:0];
            REG_FW_LOW:   fw_low = value[9:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic randomise_registers();
        write_register(REG_GAIN_P, 15'($urandom_range(0, 4095)));
        write_register(REG_GAIN_I, 15'($urandom_range(0, 4095)));
        write_register(REG_GAIN_D, 15'($urandom_range(0, 4095)));
        write_register(REG_GOAL_X, 15'($urandom));
        write_register(REG_GOAL_Y, 15'($urandom));
        write_register(REG_FW_BASE, 15'($urandom_range(0, 1023)));
        write_register(REG_FW_SCALE, 15'($urandom_range(0, 255)));
        write_register(REG_FW_LOW, 15'($urandom_range(0, 1023)));
    endtask

    // Extremes of position and heading, all buttons, zero offset, rear bearing
    task automatic test_directed_cases();
        send_request(15'sd3072, 15'sd3072, 15'd0, 1'b1, 1'b0, 1'b0);    // zero offset
        send_request(15'sd3072, 15'sd10000, 15'd0, 1'b0, 1'b1, 1'b0);   // straight behind
        send_request(15'sd3072, 15'h4000, 15'd11520, 1'b0, 1'b0, 1'b1);
        send_request(15'h4000, 15'h4000, 15'd23039, 1'b1, 1'b1, 1'b1);
        send_request(15'sd16383, 15'sd16383, 15'd0, 1'b0, 1'b0, 1'b0);
        send_request(15'sd16383, 15'h4000, 15'd32767, 1'b1, 1'b0, 1'b0);
        send_request(15'h4000, 15'sd16383, 15'd20000, 1'b0, 1'b1, 1'b1);
        send_request(15'sd0, 15'sd0, 15'd2880, 1'b1, 1'b0, 1'b0);       // near-zero error
        send_request(15'sd0, 15'sd0, 15'd2860, 1'b0, 1'b0, 1'b1);
        send_request(15'sd0, 15'sd0, 15'd2000, 1'b0, 1'b0, 1'b0);
        drain_results();
    endtask

    // Extreme register settings: full gains, saturating flywheel, far goal
    task automatic test_register_extremes();
        write_register(REG_GAIN_P, 15'd4095);
        write_register(REG_GAIN_I, 15'd4095);
        write_register(REG_GAIN_D, 15'd4095);
        write_register(REG_GOAL_X, 15'h3FFF);
        write_register(REG_GOAL_Y, 15'h4000);
        write_register(REG_FW_BASE, 15'd1023);
        write_register(REG_FW_SCALE, 15'd255);
        write_register(REG_FW_LOW, 15'd1023);
        // Aim near straight behind: the error is large, so the integral is cleared
        for (int k = 0; k < 8; k++)
            send_request(15'sd16383, 15'sd16000, 15'd0, k[0], k[1], k[2]);
        send_request(15'h4000, 15'sd16383, 15'd100, 1'b1, 1'b0, 1'b0);
        drain_results();
        write_register(REG_GAIN_P, 15'd0);
        write_register(REG_GAIN_I, 15'd0);
        write_register(REG_GAIN_D, 15'd0);
        write_register(REG_FW_BASE, 15'd0);
        write_register(REG_FW_SCALE, 15'd0);
        write_register(REG_FW_LOW, 15'd0);
        for (int k = 0; k < 4; k++) send_random_request();
        drain_results();
    endtask

    // Random traffic across several register settings, with heavy stalls late on
    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            randomise_registers();
            stress_sink = (phase >= 4);
            for (int k = 0; k < 105; k++) send_random_request();
            drain_results();
        end
    endtask

    initial begin
        mismatches    = 0;
        stress_sink   = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_GAIN_P;
        i_cfg_data    = '0;
        in_req.valid  = 1'b0;
        in_req.robot_x = '0;
        in_req.robot_y = '0;
        in_req.turret_heading = '0;
        in_req.button_fast = 1'b0;
        in_req.button_slow = 1'b0;
        in_req.button_stop = 1'b0;
        kp = 12'd640; ki = 12'd0; kd = 12'd205;
        aim_x = 15'sd3072; aim_y = 15'sd3072;
        fw_base = 10'd380; fw_scale = 8'd32; fw_low = 10'd300;
        last_err = 0;
        err_sum = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_register_extremes();
        test_random_traffic();

        if (mismatches == 0 && expected_cmds.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
